@@ hw/rtl/wvdi_pkg.sv @@
// shared types, constants and compare functions for the windowed vertex dedup indexer
// no dependencies; imported by wvdi_cell and windowed_vertex_dedup_indexer_unit

package wvdi_pkg;

    // default number of window entries
    localparam int WVDI_WINDOW = 100;

    // sign-stripped bit patterns of IEEE single special values
    localparam logic [31:0] FP_MAG_MASK = 32'h7fff_ffff;
    localparam logic [31:0] FP_INF_MAG  = 32'h7f80_0000;

    // input item
    typedef struct packed {
        logic        first_of_mesh;
        logic [31:0] position_x;
        logic [31:0] position_y;
        logic [31:0] position_z;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
    } t_in;

    // result item
    typedef struct packed {
        logic [31:0] vertex_index;
        logic        appended;
    } t_out;

    // one window entry as it moves down the chain
    typedef struct packed {
        logic        valid;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] nrm_x;
        logic [31:0] nrm_y;
        logic [31:0] nrm_z;
        logic [31:0] index;
    } t_entry;

    // search result handed from newer to older cells
    typedef struct packed {
        logic        hit;
        logic [31:0] index;
    } t_carry;

    // controls broadcast to every cell
    typedef struct packed {
        logic shift;
        logic clear_valid;
        logic clear_carry;
        logic sweep;
    } t_cell_ctl;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    function automatic logic is_zero32(input logic [31:0] v);
        return (v & FP_MAG_MASK) == 32'd0;
    endfunction

    function automatic logic is_nan32(input logic [31:0] v);
        return (v & FP_MAG_MASK) > FP_INF_MAG;
    endfunction

    // floating-point equality: signed zeros match, nan matches nothing
    function automatic logic feq32(input logic [31:0] a, input logic [31:0] b);
        logic res;
        if (is_nan32(a) || is_nan32(b)) begin
            res = 1'b0;
        end else if (is_zero32(a) && is_zero32(b)) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/wvdi_cell.sv @@
// one window cell: holds an entry, compares it with the query, passes entry and search carry on
// depends on wvdi_pkg

module wvdi_cell
    import wvdi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_in       i_query,
    input  t_entry    i_prev_entry,
    input  t_carry    i_prev_carry,
    output t_entry    o_entry,
    output t_carry    o_carry
);

    logic        r_valid;
    t_entry      r_entry;
    logic        r_hit;
    logic [31:0] r_hit_index;
    logic        w_match;

    // compare stored entry with the held query
    assign w_match = r_valid
        && feq32(r_entry.pos_x, i_query.position_x)
        && feq32(r_entry.pos_y, i_query.position_y)
        && feq32(r_entry.pos_z, i_query.position_z)
        && feq32(r_entry.nrm_x, i_query.normal_x)
        && feq32(r_entry.nrm_y, i_query.normal_y)
        && feq32(r_entry.nrm_z, i_query.normal_z);

    // valid bit of this entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear_valid) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_prev_entry.valid;
        end
    end

    // entry payload shifts in from the newer neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_prev_entry;
        end
    end

    // search carry: an older match overrides anything seen in newer cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.clear_carry) begin
            r_hit <= 1'b0;
        end else if (i_ctl.sweep) begin
            r_hit <= w_match || i_prev_carry.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep) begin
            r_hit_index <= w_match ? r_entry.index : i_prev_carry.index;
        end
    end

    assign o_entry       = '{valid: r_valid, pos_x: r_entry.pos_x, pos_y: r_entry.pos_y,
                             pos_z: r_entry.pos_z, nrm_x: r_entry.nrm_x,
                             nrm_y: r_entry.nrm_y, nrm_z: r_entry.nrm_z,
                             index: r_entry.index};
    assign o_carry.hit   = r_hit;
    assign o_carry.index = r_hit_index;

endmodule

@@ hw/rtl/windowed_vertex_dedup_indexer_unit.sv @@
// windowed vertex dedup indexer: a chain of WINDOW cells, newest entry at cell 0
// idle takes input, sweep searches, finish registers the result when the output is free
// one item in flight; a query with some zero normal skips the sweep and is appended
// during the sweep the search carry walks the cell chain one cell per cycle
// reset (synchronous, active low) empties the window and zeroes the count; no clearing pass
// depends on wvdi_pkg and wvdi_cell

module windowed_vertex_dedup_indexer_unit
    import wvdi_pkg::*;
#(
    parameter int WINDOW = WVDI_WINDOW
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(WINDOW - 1);

    t_state      r_state, n_state;
    t_in         r_query;
    logic [31:0] r_count, n_count;
    logic [CW-1:0] r_step, n_step;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;
    t_cell_ctl   w_ctl;
    logic        w_in_xfer;
    logic        w_search;
    t_entry      w_new_entry;
    t_entry      w_entry [WINDOW];
    t_carry      w_carry [WINDOW];

    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_search  = !is_zero32(i_in_data.normal_x) && !is_zero32(i_in_data.normal_y)
                    && !is_zero32(i_in_data.normal_z);

    // entry that enters cell 0 on an append
    assign w_new_entry = '{valid: 1'b1, pos_x: r_query.position_x,
                           pos_y: r_query.position_y, pos_z: r_query.position_z,
                           nrm_x: r_query.normal_x, nrm_y: r_query.normal_y,
                           nrm_z: r_query.normal_z, index: r_count};

    // state, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= 32'd0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_in_xfer) begin
            r_query <= i_in_data;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_ctl       = '0;
        o_in_ready  = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.clear_carry = 1'b1;
                    w_ctl.clear_valid = i_in_data.first_of_mesh;
                    if (i_in_data.first_of_mesh) begin
                        n_count = 32'd0;
                    end
                    n_step  = '0;
                    n_state = w_search ? ST_SWEEP : ST_FINISH;
                end
            end
            ST_SWEEP: begin
                w_ctl.sweep = 1'b1;
                n_step      = r_step + CW'(1);
                if (r_step == LAST_STEP) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (w_carry[WINDOW-1].hit) begin
                        n_out.vertex_index = w_carry[WINDOW-1].index;
                        n_out.appended     = 1'b0;
                    end else begin
                        n_out.vertex_index = r_count;
                        n_out.appended     = 1'b1;
                        w_ctl.shift        = 1'b1;
                        n_count            = r_count + 32'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // cell chain
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        t_entry w_prev_entry;
        t_carry w_prev_carry;
        if (g == 0) begin : g_head
            assign w_prev_entry = w_new_entry;
            assign w_prev_carry = '0;
        end else begin : g_link
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_carry = w_carry[g-1];
        end
        wvdi_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_query      (r_query),
            .i_prev_entry (w_prev_entry),
            .i_prev_carry (w_prev_carry),
            .o_entry      (w_entry[g]),
            .o_carry      (w_carry[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
